/* src/awve_pkg.sv */
// Shared types and constants for the adaptive window velocity estimator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package awve_pkg;

  localparam int POS_W   = 32;
  localparam int TIME_W  = 32;
  localparam int DIFF_W  = POS_W + 1;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DIV_W   = 53;
  localparam int STEP_W  = 4;
  localparam int DEPTH_W = 5;
  localparam int BAND_W  = 16;
  localparam int WIN_W   = 5;
  localparam int VEL_SCALE = 1000000;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEPTH = 2'd0;
  localparam logic [1:0] REG_BAND  = 2'd1;
  localparam logic [1:0] REG_CAP   = 2'd2;

  // Multiplier operations.
  localparam logic [1:0] MUL_BAND = 2'd0;  // fit_band * dt
  localparam logic [1:0] MUL_AD   = 2'd1;  // point offset * dt
  localparam logic [1:0] MUL_BE   = 2'd2;  // end offset * point time
  localparam logic [1:0] MUL_VM   = 2'd3;  // |end offset| * 1e6

  // Axis codes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       ld_new;
    logic       ld_old;
    logic       ld_pt;
    logic       mul_go;
    logic [1:0] mul_op;
    logic       diff;
    logic       div_start;
    logic       out_load;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic fit;
    logic div_done;
  } status_t;

endpackage

/* src/adaptive_window_velocity_estimator.sv */
// Top level of the adaptive window velocity estimator: configuration registers
// and the stream ports. Depends on awve_pkg, awve_ctrl and awve_datapath.
`timescale 1ns / 1ps
// Usage:
// Position samples arrive on the s_axis channel, one per beat. Each sample is
// stored in a ring of MAX_HISTORY entries; from the second held sample on, one
// result beat leaves on m_axis with the velocity over the largest window whose
// intermediate samples all lie within fit_band of the end-point line.
// The cfg channel writes history_depth (0), fit_band (1) and window_cap (2);
// it is always ready and should be used only while the block is idle.
// Each result needs three velocity divides of 53 quotient bits, one per axis,
// after the window search. Each tried window fetches every intermediate sample
// in turn and tests it on each axis. The multiplier and divider are shared, so
// one item is processed at a time and s_axis_tready is low while it runs.
// Reset clears the ring fill count, write slot and output valid and restores
// the register defaults. A finished result waits in the output register while
// the next sample is accepted; if the receiver still stalls when the next
// result is ready, the block holds and s_axis_tready stays low.
module adaptive_window_velocity_estimator #(
  parameter int MAX_HISTORY = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // pos_x, pos_y, pos_z, stamp_us
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // vel_x, vel_y, vel_z, window_samples, pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import awve_pkg::*;

  logic [DEPTH_W-1:0] history_depth;
  logic [BAND_W-1:0] fit_band;
  logic [STEP_W-1:0] window_cap;
  cmd_t cmd;
  status_t st;
  logic [$clog2(MAX_HISTORY)-1:0] wr_addr, rd_addr;
  logic [STEP_W-1:0] win_steps;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      history_depth <= DEPTH_W'(15);
      fit_band <= BAND_W'(655);
      window_cap <= STEP_W'(10);
    end else if (cfg_valid) begin
      priority case (cfg_index)
        REG_DEPTH: history_depth <= cfg_data[DEPTH_W-1:0];
        REG_BAND:  fit_band <= cfg_data;
        REG_CAP:   window_cap <= cfg_data[STEP_W-1:0];
        default:   ;
      endcase
    end
  end

  awve_ctrl #(.MAX_HISTORY(MAX_HISTORY)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .history_depth(history_depth), .window_cap(window_cap),
    .st(st), .cmd(cmd), .wr_addr(wr_addr), .rd_addr(rd_addr),
    .win_steps(win_steps)
  );

  awve_datapath #(.MAX_HISTORY(MAX_HISTORY)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .wr_addr(wr_addr), .rd_addr(rd_addr), .win_steps(win_steps),
    .fit_band(fit_band), .in_data(s_axis_tdata), .out_data(m_axis_tdata)
  );

endmodule

/* src/awve_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module awve_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/awve_datapath.sv */
// Datapath: sample history RAM, shared multiplier, band test and serial divider.
// Depends on awve_pkg and awve_ram; driven by awve_ctrl commands.
`timescale 1ns / 1ps
module awve_datapath #(
  parameter int MAX_HISTORY = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  awve_pkg::cmd_t                 cmd,
  output awve_pkg::status_t              st,
  input  logic [$clog2(MAX_HISTORY)-1:0] wr_addr,
  input  logic [$clog2(MAX_HISTORY)-1:0] rd_addr,
  input  logic [awve_pkg::STEP_W-1:0]    win_steps,
  input  logic [awve_pkg::BAND_W-1:0]    fit_band,
  input  logic [127:0]                   in_data,
  output logic [103:0]                   out_data
);
  import awve_pkg::*;

  logic [127:0] rdata;
  logic [POS_W-1:0] nx, ny, nz, ox, oy, oz;
  logic [TIME_W-1:0] nt, ot, d, e;
  logic dz;
  logic signed [DIFF_W-1:0] bx, by, bz, ax, ay, az, a_sel, b_sel;
  logic signed [MUL_W-1:0] mx, my, d_eff;
  logic signed [PROD_W-1:0] prod, pa, pb, r, bandd;
  logic signed [PROD_W:0] lo, hi;
  logic [DIV_W-1:0] mprod, dvd;
  logic [TIME_W-1:0] rem;
  logic [TIME_W:0] rem_sh;
  logic [5:0] cnt;
  logic busy, sat_pend, neg, div_done;
  logic [1:0] daxis;
  logic [POS_W-1:0] vx, vy, vz, vres;

  awve_ram #(.WIDTH(128), .DEPTH(MAX_HISTORY)) u_hist (
    .clk(clk), .we(cmd.ld_new), .waddr(wr_addr), .wdata(in_data),
    .raddr(rd_addr), .rdata(rdata)
  );

  // Axis selection of the offsets.
  always_comb begin
    unique case (cmd.axis)
      AXIS_X:  begin a_sel = ax; b_sel = bx; end
      AXIS_Y:  begin a_sel = ay; b_sel = by; end
      default: begin a_sel = az; b_sel = bz; end
    endcase
  end

  // Shared multiplier; a zero time span turns the test into |a| <= band.
  assign d_eff = dz ? MUL_W'(1) : MUL_W'({1'b0, d});
  always_comb begin
    unique case (cmd.mul_op)
      MUL_BAND: begin mx = MUL_W'({1'b0, fit_band}); my = d_eff; end
      MUL_AD:   begin mx = MUL_W'(a_sel); my = d_eff; end
      MUL_BE:   begin mx = MUL_W'(b_sel); my = dz ? '0 : MUL_W'({1'b0, e}); end
      default:  begin
        mx = b_sel[DIFF_W-1] ? MUL_W'(-b_sel) : MUL_W'(b_sel);
        my = MUL_W'(VEL_SCALE);
      end
    endcase
  end
  assign prod = mx * my;

  // Band test on the registered residual.
  assign lo = {r[PROD_W-1], r} + {bandd[PROD_W-1], bandd};
  assign hi = {r[PROD_W-1], r} - {bandd[PROD_W-1], bandd};
  assign st.fit = !lo[PROD_W] && (hi[PROD_W] || hi == '0);
  assign st.div_done = div_done;

  // Sample registers and products.
  always_ff @(posedge clk) begin
    if (cmd.ld_new) begin
      {nt, nz, ny, nx} <= in_data;
    end
    if (cmd.ld_old) begin
      {ot, oz, oy, ox} <= rdata;
      bx <= DIFF_W'(signed'(nx)) - DIFF_W'(signed'(rdata[31:0]));
      by <= DIFF_W'(signed'(ny)) - DIFF_W'(signed'(rdata[63:32]));
      bz <= DIFF_W'(signed'(nz)) - DIFF_W'(signed'(rdata[95:64]));
      d  <= nt - rdata[127:96];
      dz <= (nt == rdata[127:96]);
    end
    if (cmd.ld_pt) begin
      ax <= DIFF_W'(signed'(rdata[31:0]))  - DIFF_W'(signed'(ox));
      ay <= DIFF_W'(signed'(rdata[63:32])) - DIFF_W'(signed'(oy));
      az <= DIFF_W'(signed'(rdata[95:64])) - DIFF_W'(signed'(oz));
      e  <= rdata[127:96] - ot;
    end
    if (cmd.mul_go) begin
      unique case (cmd.mul_op)
        MUL_BAND: bandd <= prod;
        MUL_AD:   pa <= prod;
        MUL_BE:   pb <= prod;
        default:  mprod <= prod[DIV_W-1:0];
      endcase
    end
    if (cmd.diff) begin
      r <= pa - pb;
    end
  end

  // Saturated, sign-restored quotient.
  always_comb begin
    if (neg) begin
      vres = (dvd > DIV_W'(33'h080000000)) ? 32'h80000000 : POS_W'(-dvd);
    end else begin
      vres = (dvd > DIV_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : dvd[POS_W-1:0];
    end
  end

  // Restoring divider, one quotient bit a cycle.
  assign rem_sh = {rem, dvd[DIV_W-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sat_pend <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= !cmd.div_start && !busy && sat_pend;
      if (cmd.div_start) begin
        daxis <= cmd.axis;
        rem <= '0;
        cnt <= 6'(DIV_W);
        if (dz) begin
          dvd <= '0;
          neg <= 1'b0;
          sat_pend <= 1'b1;
        end else begin
          dvd <= mprod + DIV_W'(d >> 1);
          neg <= b_sel[DIFF_W-1];
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (rem_sh >= {1'b0, d}) begin
          rem <= TIME_W'(rem_sh - {1'b0, d});
          dvd <= {dvd[DIV_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[TIME_W-1:0];
          dvd <= {dvd[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          sat_pend <= 1'b1;
        end
      end else if (sat_pend) begin
        sat_pend <= 1'b0;
        unique case (daxis)
          AXIS_X:  vx <= vres;
          AXIS_Y:  vy <= vres;
          default: vz <= vres;
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {3'b000, WIN_W'(win_steps) + WIN_W'(1), vz, vy, vx};
    end
  end

endmodule

/* src/awve_ctrl.sv */
// Controller: ring bookkeeping, window growth, band test and divide sequencing.
// Depends on awve_pkg; issues commands to awve_datapath.
`timescale 1ns / 1ps
module awve_ctrl #(
  parameter int MAX_HISTORY = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic [awve_pkg::DEPTH_W-1:0]   history_depth,
  input  logic [awve_pkg::STEP_W-1:0]    window_cap,
  input  awve_pkg::status_t              st,
  output awve_pkg::cmd_t                 cmd,
  output logic [$clog2(MAX_HISTORY)-1:0] wr_addr,
  output logic [$clog2(MAX_HISTORY)-1:0] rd_addr,
  output logic [awve_pkg::STEP_W-1:0]    win_steps
);
  import awve_pkg::*;

  localparam int SW = $clog2(MAX_HISTORY);
  localparam int FW = $clog2(MAX_HISTORY + 1);
  localparam int CW = (FW > DEPTH_W) ? FW : DEPTH_W;
  localparam int BW = $clog2(2 * MAX_HISTORY);

  localparam logic [4:0] ST_IDLE = 5'd0,  ST_CALC = 5'd1,  ST_TRY = 5'd2,
                         ST_OLD = 5'd3,   ST_BD = 5'd4,    ST_PTRD = 5'd5,
                         ST_PTLD = 5'd6,  ST_MA = 5'd7,    ST_MB = 5'd8,
                         ST_DF = 5'd9,    ST_CK = 5'd10,   ST_FIN = 5'd11,
                         ST_FOLD = 5'd12, ST_VM = 5'd13,   ST_DVS = 5'd14,
                         ST_DVW = 5'd15,  ST_OUT = 5'd16;

  logic [4:0] state, state_next;
  logic [FW-1:0] fill, fill_next;
  logic [SW-1:0] wslot, wslot_next;
  logic [STEP_W-1:0] s, s_next, t, t_next, j, j_next, smax, smax_next, k_sel;
  logic [1:0] axis, axis_next;
  logic out_valid_next;
  logic [CW-1:0] depth_eff, n, nm1;
  logic [STEP_W-1:0] cap_eff;

  // Slot of the sample k steps back from the newest.
  function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] ws,
                                               input logic [STEP_W-1:0] k);
    logic [BW-1:0] tmp;
    tmp = BW'(ws) + BW'(MAX_HISTORY - 1) - BW'(k);
    if (tmp >= BW'(MAX_HISTORY)) begin
      tmp = tmp - BW'(MAX_HISTORY);
    end
    return tmp[SW-1:0];
  endfunction

  // Search limits from the fill level and the registers.
  always_comb begin
    if (CW'(history_depth) < CW'(2)) begin
      depth_eff = CW'(2);
    end else if (CW'(history_depth) > CW'(MAX_HISTORY)) begin
      depth_eff = CW'(MAX_HISTORY);
    end else begin
      depth_eff = CW'(history_depth);
    end
    n = (CW'(fill) < depth_eff) ? CW'(fill) : depth_eff;
    nm1 = n - CW'(1);
    cap_eff = (window_cap == '0) ? STEP_W'(1) : window_cap;
  end

  assign wr_addr = wslot;
  assign rd_addr = slot_back(wslot, k_sel);
  assign in_ready = (state == ST_IDLE);
  assign win_steps = s;

  // Next-state and command logic.
  always_comb begin
    state_next = state;
    fill_next = fill;
    wslot_next = wslot;
    s_next = s;
    t_next = t;
    j_next = j;
    smax_next = smax;
    axis_next = axis;
    out_valid_next = out_valid && !out_ready;
    k_sel = s;
    cmd = '0;
    cmd.axis = axis;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_new = 1'b1;
          wslot_next = (wslot == SW'(MAX_HISTORY - 1)) ? '0 : wslot + SW'(1);
          if (fill < FW'(MAX_HISTORY)) begin
            fill_next = fill + FW'(1);
          end
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (n < CW'(2)) begin
          state_next = ST_IDLE;
        end else begin
          s_next = STEP_W'(1);
          smax_next = (nm1 > CW'(cap_eff)) ? cap_eff : nm1[STEP_W-1:0];
          state_next = ST_TRY;
        end
      end
      ST_TRY: begin
        k_sel = s + STEP_W'(1);
        if (s < smax) begin
          t_next = s + STEP_W'(1);
          state_next = ST_OLD;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_OLD: begin
        cmd.ld_old = 1'b1;
        state_next = ST_BD;
      end
      ST_BD: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = MUL_BAND;
        j_next = STEP_W'(1);
        state_next = ST_PTRD;
      end
      ST_PTRD: begin
        k_sel = j;
        if (j < t) begin
          state_next = ST_PTLD;
        end else begin
          s_next = t;
          state_next = ST_TRY;
        end
      end
      ST_PTLD: begin
        cmd.ld_pt = 1'b1;
        axis_next = AXIS_X;
        state_next = ST_MA;
      end
      ST_MA: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = MUL_AD;
        state_next = ST_MB;
      end
      ST_MB: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = MUL_BE;
        state_next = ST_DF;
      end
      ST_DF: begin
        cmd.diff = 1'b1;
        state_next = ST_CK;
      end
      ST_CK: begin
        if (!st.fit) begin
          state_next = ST_FIN;
        end else if (axis == AXIS_Z) begin
          j_next = j + STEP_W'(1);
          state_next = ST_PTRD;
        end else begin
          axis_next = axis + 2'd1;
          state_next = ST_MA;
        end
      end
      ST_FIN: begin
        state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.ld_old = 1'b1;
        axis_next = AXIS_X;
        state_next = ST_VM;
      end
      ST_VM: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = MUL_VM;
        state_next = ST_DVS;
      end
      ST_DVS: begin
        cmd.div_start = 1'b1;
        state_next = ST_DVW;
      end
      ST_DVW: begin
        if (st.div_done) begin
          if (axis == AXIS_Z) begin
            state_next = ST_OUT;
          end else begin
            axis_next = axis + 2'd1;
            state_next = ST_VM;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      wslot <= '0;
      out_valid <= 1'b0;
      s <= '0;
      t <= '0;
      j <= '0;
      smax <= '0;
      axis <= AXIS_X;
    end else begin
      state <= state_next;
      fill <= fill_next;
      wslot <= wslot_next;
      out_valid <= out_valid_next;
      s <= s_next;
      t <= t_next;
      j <= j_next;
      smax <= smax_next;
      axis <= axis_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_calc: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_CALC)
    else $error("accepted beat did not start a search");
  a_s_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_TRY |-> s <= smax)
    else $error("window grew past its limit");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(MAX_HISTORY))
    else $error("fill count overflow");
  a_point_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_PTLD |-> j < t && j != '0)
    else $error("intermediate sample outside window");
`endif

endmodule
